/* hw/rtl/rss_pkg.sv */
// Shared definitions for the range shift selector: register indexes, microcode
// step and condition codes, the control store, and the per-shift error function.
// Depends on nothing else.
package rss_pkg;

	localparam int SampleWidth = 16;
	localparam int MagWidth    = 15;
	localparam int ShiftWidth  = 5;
	localparam int IndexWidth  = 3;
	localparam int DataWidth   = 15;
	localparam int UpcWidth    = 2;

	localparam logic [IndexWidth-1:0] REG_CURRENT_PRECISION = 3'd0;
	localparam logic [IndexWidth-1:0] REG_NEW_WIDTH         = 3'd1;
	localparam logic [IndexWidth-1:0] REG_SHIFT_TOLERANCE   = 3'd2;
	localparam logic [IndexWidth-1:0] REG_LOW_SHIFT         = 3'd3;
	localparam logic [IndexWidth-1:0] REG_HIGH_SHIFT        = 3'd4;

	localparam logic [UpcWidth-1:0] UPC_WAIT = 2'd0;
	localparam logic [UpcWidth-1:0] UPC_PREV = 2'd1;
	localparam logic [UpcWidth-1:0] UPC_SCAN = 2'd2;
	localparam logic [UpcWidth-1:0] UPC_EMIT = 2'd3;

	localparam logic [1:0] OP_IDLE = 2'd0;
	localparam logic [1:0] OP_PREV = 2'd1;
	localparam logic [1:0] OP_SCAN = 2'd2;
	localparam logic [1:0] OP_EMIT = 2'd3;

	localparam logic [1:0] COND_ACCEPT    = 2'd0;
	localparam logic [1:0] COND_PREV_DONE = 2'd1;
	localparam logic [1:0] COND_SCAN_END  = 2'd2;
	localparam logic [1:0] COND_OUT_FREE  = 2'd3;

	typedef struct packed {
		logic [1:0]          op;
		logic [1:0]          cond;
		logic [UpcWidth-1:0] jump;
		logic [UpcWidth-1:0] fall;
	} ctrl_t;

	function automatic ctrl_t ucode_rom(input logic [UpcWidth-1:0] upc);
		ctrl_t w;
		case (upc)
			UPC_WAIT: w = '{op: OP_IDLE, cond: COND_ACCEPT, jump: UPC_PREV, fall: UPC_WAIT};
			UPC_PREV: w = '{op: OP_PREV, cond: COND_PREV_DONE, jump: UPC_EMIT, fall: UPC_SCAN};
			UPC_SCAN: w = '{op: OP_SCAN, cond: COND_SCAN_END, jump: UPC_EMIT, fall: UPC_SCAN};
			UPC_EMIT: w = '{op: OP_EMIT, cond: COND_OUT_FREE, jump: UPC_WAIT, fall: UPC_EMIT};
			default:  w = '{op: OP_IDLE, cond: COND_ACCEPT, jump: UPC_PREV, fall: UPC_WAIT};
		endcase
		return w;
	endfunction

	// The reconstruction keeps the magnitude bits under a shifted data mask, so
	// the error is the magnitude with those bits cleared.
	function automatic logic [MagWidth-1:0] shift_err(
		input logic [MagWidth-1:0]   mag,
		input logic [3:0]            width,
		input logic [ShiftWidth:0]   s
	);
		logic [6:0]          c;
		logic [6:0]          neg_c;
		logic [MagWidth-1:0] wmask;
		logic [MagWidth-1:0] keep;
		c     = 7'd16 - {3'b000, width} + {s[ShiftWidth], s};
		neg_c = 7'd0 - c;
		if (width == 4'd0) begin
			wmask = '0;
		end else begin
			wmask = (MagWidth'(1) << (width - 4'd1)) - MagWidth'(1);
		end
		if ($signed(c) >= 7'sd16 || $signed(c) <= -7'sd16) begin
			keep = '0;
		end else if ($signed(c) >= 7'sd0) begin
			keep = wmask << c[3:0];
		end else begin
			keep = wmask >> neg_c[3:0];
		end
		return mag & ~keep;
	endfunction

endpackage

/* hw/rtl/range_shift_selector_core.sv */
// Top level of the range shift selector: configuration registers, a small
// microcoded sequencer and its datapath that tries one candidate shift a cycle.
// Depends on rss_pkg.
//
// Usage: samples enter on the input channel (in_valid, in_stall, sample,
// start_of_block); one shift leaves on the output channel (out_valid, out_stall,
// shift) for every input transaction, in order. Configuration writes use
// cfg_valid, cfg_ready, cfg_index and cfg_data and are always taken. The user
// must make them only while the block is idle; the block does not enforce it.
// Indexes beyond the register list are ignored. An input transaction is
// followed by one step that checks the previous shift. If it is kept, or the
// target width is 16 or more, the sequencer goes straight to the emit step,
// which loads the result register. Otherwise it scans the low shift to the high
// shift, one candidate per cycle, and then goes to the emit step, also when the range is empty.
// The input is taken only while the sequencer waits at its first step. A
// result waits in the output register while the receiver stalls; the next
// sample can still be accepted and worked on, and the sequencer holds at its
// last step until the register frees. Reset empties the output register,
// loads the register defaults and sets the previous shift to -3.
module range_shift_selector_core
	import rss_pkg::*;
(
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [SampleWidth-1:0] sample,
	input  logic                          start_of_block,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [ShiftWidth-1:0]  shift,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [IndexWidth-1:0]         cfg_index,
	input  logic [DataWidth-1:0]          cfg_data
);

	logic [4:0]                   current_precision_q;
	logic [4:0]                   new_width_q;
	logic [DataWidth-1:0]         shift_tolerance_q;
	logic signed [ShiftWidth-1:0] low_shift_q;
	logic signed [ShiftWidth-1:0] high_shift_q;

	logic [UpcWidth-1:0]          upc_q;
	logic signed [ShiftWidth-1:0] prev_q;
	logic signed [ShiftWidth-1:0] chosen_q;
	logic signed [ShiftWidth:0]   cand_q;
	logic [MagWidth-1:0]          mag_q;
	logic [MagWidth-1:0]          best_err_q;
	logic                         out_valid_q;
	logic signed [ShiftWidth-1:0] shift_q;

	ctrl_t                        ctrl;
	logic                         take;
	logic                         in_fire;
	logic                         out_free;
	logic                         wide;
	logic [MagWidth-1:0]          prev_err;
	logic [MagWidth-1:0]          cand_err;
	logic                         scan_end;
	logic [SampleWidth-1:0]       neg_sample;
	logic [MagWidth-1:0]          mag_next;
	logic                         unused_precision;

	assign cfg_ready = 1'b1;
	assign in_stall  = (upc_q != UPC_WAIT);
	assign in_fire   = in_valid & ~in_stall;
	assign out_valid = out_valid_q;
	assign shift     = shift_q;
	assign out_free  = ~out_valid_q | ~out_stall;

	// The sample precision cancels out of the shift arithmetic.
	assign unused_precision = ^current_precision_q;

	assign ctrl     = ucode_rom(upc_q);
	assign wide     = (new_width_q >= 5'd16);
	assign prev_err = shift_err(mag_q, new_width_q[3:0], {prev_q[ShiftWidth-1], prev_q});
	assign cand_err = shift_err(mag_q, new_width_q[3:0], cand_q);
	assign scan_end = (cand_q > $signed({high_shift_q[ShiftWidth-1], high_shift_q}));

	assign neg_sample = 16'd0 - sample;
	always_comb begin
		if (!sample[SampleWidth-1]) begin
			mag_next = sample[MagWidth-1:0];
		end else if (sample == 16'sh8000) begin
			mag_next = 15'h7fff;
		end else begin
			mag_next = neg_sample[MagWidth-1:0];
		end
	end

	always_comb begin
		case (ctrl.cond)
			COND_ACCEPT:    take = in_fire;
			COND_PREV_DONE: take = wide || (prev_err <= shift_tolerance_q);
			COND_SCAN_END:  take = scan_end;
			COND_OUT_FREE:  take = out_free;
			default:        take = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			current_precision_q <= 5'd13;
			new_width_q         <= 5'd8;
			shift_tolerance_q   <= '0;
			low_shift_q         <= -5'sd3;
			high_shift_q        <= 5'sd3;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_CURRENT_PRECISION: current_precision_q <= cfg_data[4:0];
				REG_NEW_WIDTH:         new_width_q         <= cfg_data[4:0];
				REG_SHIFT_TOLERANCE:   shift_tolerance_q   <= cfg_data;
				REG_LOW_SHIFT:         low_shift_q         <= cfg_data[4:0];
				REG_HIGH_SHIFT:        high_shift_q        <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q       <= UPC_WAIT;
			prev_q      <= -5'sd3;
			out_valid_q <= 1'b0;
		end else begin
			upc_q <= take ? ctrl.jump : ctrl.fall;
			if (ctrl.op == OP_IDLE && in_fire && start_of_block) begin
				prev_q <= low_shift_q;
			end
			if (ctrl.op == OP_EMIT && out_free) begin
				out_valid_q <= 1'b1;
				prev_q      <= chosen_q;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (ctrl.op)
			OP_IDLE: begin
				if (in_fire) begin
					mag_q <= mag_next;
				end
			end
			OP_PREV: begin
				chosen_q   <= wide ? '0 : prev_q;
				best_err_q <= prev_err;
				cand_q     <= {low_shift_q[ShiftWidth-1], low_shift_q};
			end
			OP_SCAN: begin
				if (!scan_end) begin
					if (cand_q != {prev_q[ShiftWidth-1], prev_q} && cand_err < best_err_q) begin
						best_err_q <= cand_err;
						chosen_q   <= cand_q[ShiftWidth-1:0];
					end
					cand_q <= cand_q + 6'sd1;
				end
			end
			OP_EMIT: begin
				if (out_free) begin
					shift_q <= chosen_q;
				end
			end
			default: ;
		endcase
	end

`ifndef SYNTHESIS
	a_accept_starts_program: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> (upc_q == UPC_PREV))
		else $error("accepted sample did not start the program");

	a_result_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(upc_q) == UPC_EMIT))
		else $error("result appeared outside the emit step");

	a_best_never_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(upc_q == UPC_SCAN) |=> (best_err_q <= $past(best_err_q)))
		else $error("best error grew during the scan");

	a_scan_only_after_miss: assert property (@(posedge clk) disable iff (!arst_n)
		(upc_q == UPC_PREV && wide) |=> (upc_q == UPC_EMIT))
		else $error("wide target entered the scan");
`endif

endmodule
